// File: sv/assert_macros.svh
// Assertion helpers for the dispatcher checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define RLRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlrd check failed");

// Next-cycle implication, gated by reset.
`define RLRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlrd check failed");

`endif

// File: sv/rlrd_pkg.sv
package rlrd_pkg;

    localparam int unsigned MILLI = 1000;
    localparam int unsigned EXP_LIMIT = 20;
    localparam int unsigned PROD_W = 26;

    // input commands
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ENQ  = 2'd1;
    localparam logic [1:0] CMD_CPL  = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    // completion outcomes
    localparam logic [1:0] OUTC_OK   = 2'd0;
    localparam logic [1:0] OUTC_TEMP = 2'd1;

    // result events
    localparam logic [2:0] EV_ISSUED  = 3'd0;
    localparam logic [2:0] EV_DONE    = 3'd1;
    localparam logic [2:0] EV_RETRY   = 3'd2;
    localparam logic [2:0] EV_DROP    = 3'd3;
    localparam logic [2:0] EV_REFUSED = 3'd4;
    localparam logic [2:0] EV_LOST    = 3'd5;

    // config register indexes
    localparam logic [2:0] CFG_ORDER_RATE  = 3'd0;
    localparam logic [2:0] CFG_ORDER_BURST = 3'd1;
    localparam logic [2:0] CFG_MSG_RATE    = 3'd2;
    localparam logic [2:0] CFG_MAX_INFL    = 3'd3;
    localparam logic [2:0] CFG_BO_BASE     = 3'd4;
    localparam logic [2:0] CFG_BO_CAP      = 3'd5;

    // config reset values
    localparam logic [15:0] RST_ORDER_RATE  = 16'd10;
    localparam logic [15:0] RST_ORDER_BURST = 16'd5;
    localparam logic [15:0] RST_MSG_RATE    = 16'd50;
    localparam logic [7:0]  RST_MAX_INFL    = 8'd4;
    localparam logic [15:0] RST_BO_BASE     = 16'd100;
    localparam logic [15:0] RST_BO_CAP      = 16'd5000;
    localparam logic [PROD_W-1:0] RST_ORDER_TOK = PROD_W'(5 * 1000);
    localparam logic [PROD_W-1:0] RST_MSG_TOK   = PROD_W'(50 * 1000);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_REFILL,
        ST_SCAN,
        ST_PICK,
        ST_ENQ,
        ST_CPL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul_load;
        logic div_step;
        logic refill;
        logic scan;
        logic issue;
        logic enq_push;
        logic enq_refuse;
        logic cpl;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd_code;
        logic       q_full;
        logic       issue_ok;
        logic       out_free;
    } ctrl_sts_t;

endpackage

// File: sv/rlrd_ctrl.sv
module rlrd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  rlrd_pkg::ctrl_sts_t   sts,
    output rlrd_pkg::ctrl_cmd_t   cmd
);

    rlrd_pkg::state_t state_reg;
    rlrd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlrd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlrd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (sts.cmd_code)
                        rlrd_pkg::CMD_TICK: state_next = rlrd_pkg::ST_MUL;
                        rlrd_pkg::CMD_ENQ:  state_next = rlrd_pkg::ST_ENQ;
                        rlrd_pkg::CMD_CPL:  state_next = rlrd_pkg::ST_CPL;
                        default:            state_next = rlrd_pkg::ST_IDLE;
                    endcase
                end
            end
            rlrd_pkg::ST_MUL:    state_next = rlrd_pkg::ST_DIV;
            rlrd_pkg::ST_DIV:    state_next = rlrd_pkg::ST_REFILL;
            rlrd_pkg::ST_REFILL: state_next = rlrd_pkg::ST_SCAN;
            rlrd_pkg::ST_SCAN:   state_next = rlrd_pkg::ST_PICK;
            rlrd_pkg::ST_PICK:
                state_next = sts.issue_ok ? rlrd_pkg::ST_EMIT : rlrd_pkg::ST_IDLE;
            rlrd_pkg::ST_ENQ:
                state_next = sts.q_full ? rlrd_pkg::ST_EMIT : rlrd_pkg::ST_IDLE;
            rlrd_pkg::ST_CPL:    state_next = rlrd_pkg::ST_EMIT;
            rlrd_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = rlrd_pkg::ST_IDLE;
                end
            end
            default:             state_next = rlrd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            rlrd_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            rlrd_pkg::ST_MUL:    cmd.mul_load = 1'b1;
            rlrd_pkg::ST_DIV:    cmd.div_step = 1'b1;
            rlrd_pkg::ST_REFILL: cmd.refill = 1'b1;
            rlrd_pkg::ST_SCAN:   cmd.scan = 1'b1;
            rlrd_pkg::ST_PICK:   cmd.issue = sts.issue_ok;
            rlrd_pkg::ST_ENQ:
            begin
                cmd.enq_push   = !sts.q_full;
                cmd.enq_refuse = sts.q_full;
            end
            rlrd_pkg::ST_CPL:    cmd.cpl = 1'b1;
            rlrd_pkg::ST_EMIT:   cmd.emit = sts.out_free;
            default:             cmd = '0;
        endcase
    end

endmodule

// File: sv/rlrd_dp.sv
module rlrd_dp #(
    parameter int QUEUE_DEPTH      = 16,
    parameter int TICKS_PER_SECOND = 1000,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           command,
    input  logic [15:0]          order_tag,
    input  logic [7:0]           attempts,
    input  logic [1:0]           outcome,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           event_res,
    output logic [15:0]          result_tag,
    output logic [7:0]           result_attempts,
    output logic [15:0]          retry_delay,
    output logic [CNT_W-1:0]     queued,
    output logic [7:0]           in_flight,
    input  rlrd_pkg::ctrl_cmd_t  cmd,
    output rlrd_pkg::ctrl_sts_t  sts
);

    localparam int PW = rlrd_pkg::PROD_W;
    // floor(x / TPS) == (x * RCP_M) >> RCP_SH for every x below 2^PW
    localparam int RCP_SH = PW + $clog2(TICKS_PER_SECOND);
    localparam longint unsigned RCP_M =
        ((64'd1 << RCP_SH) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
    localparam int PRD_W = PW + RCP_SH;
    localparam logic [PRD_W-1:0] RCP_V = PRD_W'(RCP_M);
    localparam logic [15:0] MILLI16 = 16'(rlrd_pkg::MILLI);

    // config
    logic [15:0] order_rate_reg, order_burst_reg, msg_rate_reg;
    logic [15:0] bo_base_reg, bo_cap_reg;
    logic [7:0]  max_infl_reg;

    // latched input word
    logic [15:0] tag_in_reg;
    logic [7:0]  att_in_reg;
    logic [1:0]  outc_reg;

    // buckets and clock
    logic [PW-1:0] order_tok_reg, msg_tok_reg;
    logic [PW-1:0] order_cap_reg, msg_cap_reg;
    logic [31:0]   now_reg;
    logic [7:0]    issued_reg;

    // refill amounts (order, message)
    logic [PW-1:0]    dvd_o_reg, dvd_m_reg, quo_o_reg, quo_m_reg;
    logic [PRD_W-1:0] prod_o, prod_m;

    // queue
    logic [15:0] q_tag_reg  [QUEUE_DEPTH];
    logic [7:0]  q_att_reg  [QUEUE_DEPTH];
    logic [31:0] q_elig_reg [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] flag_reg;
    logic [CNT_W-1:0] count_reg;

    // staged result
    logic [2:0]  res_ev_reg;
    logic [15:0] res_tag_reg, res_delay_reg;
    logic [7:0]  res_att_reg;

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_ev_reg;
    logic [15:0] out_tag_reg, out_delay_reg;
    logic [7:0]  out_att_reg, out_infl_reg;
    logic [CNT_W-1:0] out_q_reg;

    logic            found;
    logic [IDX_W-1:0] sel;
    logic            q_full;
    logic            issue_ok;
    logic [PW:0]     order_sum, msg_sum;
    logic [PW-1:0]   order_tok_next, msg_tok_next;
    logic [7:0]      na;
    logic [4:0]      sh;
    logic [35:0]     bo_raw;
    logic [15:0]     delay;
    logic            retry;

    assign q_full = (count_reg == CNT_W'(QUEUE_DEPTH));

    // first eligible entry in queue order
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (flag_reg[i])
            begin
                found = 1'b1;
                sel   = IDX_W'(i);
            end
        end
    end

    assign issue_ok = found && (issued_reg < max_infl_reg)
                   && (order_tok_reg >= PW'(rlrd_pkg::MILLI))
                   && (msg_tok_reg >= PW'(rlrd_pkg::MILLI));

    assign prod_o = PRD_W'(dvd_o_reg) * RCP_V;
    assign prod_m = PRD_W'(dvd_m_reg) * RCP_V;

    assign order_sum      = {1'b0, order_tok_reg} + {1'b0, quo_o_reg};
    assign msg_sum        = {1'b0, msg_tok_reg} + {1'b0, quo_m_reg};
    assign order_tok_next = (order_sum > {1'b0, order_cap_reg}) ? order_cap_reg
                                                                : order_sum[PW-1:0];
    assign msg_tok_next   = (msg_sum > {1'b0, msg_cap_reg}) ? msg_cap_reg
                                                            : msg_sum[PW-1:0];

    // backoff: min(cap, base << min(20, attempts+1))
    assign na     = (att_in_reg == 8'hFF) ? 8'hFF : att_in_reg + 8'd1;
    assign sh     = (na < 8'(rlrd_pkg::EXP_LIMIT)) ? na[4:0] : 5'(rlrd_pkg::EXP_LIMIT);
    assign bo_raw = {20'd0, bo_base_reg} << sh;
    assign delay  = (bo_raw < {20'd0, bo_cap_reg}) ? bo_raw[15:0] : bo_cap_reg;
    assign retry  = (outc_reg == rlrd_pkg::OUTC_TEMP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_rate_reg  <= rlrd_pkg::RST_ORDER_RATE;
            order_burst_reg <= rlrd_pkg::RST_ORDER_BURST;
            msg_rate_reg    <= rlrd_pkg::RST_MSG_RATE;
            max_infl_reg    <= rlrd_pkg::RST_MAX_INFL;
            bo_base_reg     <= rlrd_pkg::RST_BO_BASE;
            bo_cap_reg      <= rlrd_pkg::RST_BO_CAP;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rlrd_pkg::CFG_ORDER_RATE:  order_rate_reg  <= cfg_data;
                rlrd_pkg::CFG_ORDER_BURST: order_burst_reg <= cfg_data;
                rlrd_pkg::CFG_MSG_RATE:    msg_rate_reg    <= cfg_data;
                rlrd_pkg::CFG_MAX_INFL:    max_infl_reg    <= cfg_data[7:0];
                rlrd_pkg::CFG_BO_BASE:     bo_base_reg     <= cfg_data;
                rlrd_pkg::CFG_BO_CAP:      bo_cap_reg      <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_tok_reg <= rlrd_pkg::RST_ORDER_TOK;
            msg_tok_reg   <= rlrd_pkg::RST_MSG_TOK;
            now_reg       <= '0;
            issued_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.refill)
            begin
                now_reg       <= now_reg + 32'd1;
                order_tok_reg <= order_tok_next;
                msg_tok_reg   <= msg_tok_next;
            end
            if (cmd.issue)
            begin
                order_tok_reg <= order_tok_reg - PW'(rlrd_pkg::MILLI);
                msg_tok_reg   <= msg_tok_reg - PW'(rlrd_pkg::MILLI);
                issued_reg    <= issued_reg + 8'd1;
                count_reg     <= count_reg - CNT_W'(1);
            end
            if (cmd.enq_push)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.cpl)
            begin
                if (issued_reg != 8'd0)
                begin
                    issued_reg <= issued_reg - 8'd1;
                end
                if (retry && !q_full)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_in_reg <= order_tag;
            att_in_reg <= attempts;
            outc_reg   <= outcome;
        end
        if (cmd.mul_load)
        begin
            dvd_o_reg     <= PW'(order_rate_reg) * PW'(MILLI16);
            dvd_m_reg     <= PW'(msg_rate_reg) * PW'(MILLI16);
            order_cap_reg <= PW'(order_burst_reg) * PW'(MILLI16);
            msg_cap_reg   <= PW'(msg_rate_reg) * PW'(MILLI16);
        end
        if (cmd.div_step)
        begin
            // reciprocal scale by 1/TICKS_PER_SECOND
            quo_o_reg <= prod_o[PRD_W-1 -: PW];
            quo_m_reg <= prod_m[PRD_W-1 -: PW];
        end
        if (cmd.scan)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                flag_reg[i] <= (CNT_W'(i) < count_reg)
                            && ((now_reg - q_elig_reg[i]) < 32'h8000_0000);
            end
        end
        if (cmd.issue)
        begin
            res_ev_reg    <= rlrd_pkg::EV_ISSUED;
            res_tag_reg   <= q_tag_reg[sel];
            res_att_reg   <= q_att_reg[sel];
            res_delay_reg <= '0;
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (IDX_W'(i) >= sel)
                begin
                    q_tag_reg[i]  <= q_tag_reg[i+1];
                    q_att_reg[i]  <= q_att_reg[i+1];
                    q_elig_reg[i] <= q_elig_reg[i+1];
                end
            end
        end
        if (cmd.enq_push)
        begin
            q_tag_reg[count_reg[IDX_W-1:0]]  <= tag_in_reg;
            q_att_reg[count_reg[IDX_W-1:0]]  <= 8'd0;
            q_elig_reg[count_reg[IDX_W-1:0]] <= now_reg;
        end
        if (cmd.enq_refuse)
        begin
            res_ev_reg    <= rlrd_pkg::EV_REFUSED;
            res_tag_reg   <= tag_in_reg;
            res_att_reg   <= 8'd0;
            res_delay_reg <= '0;
        end
        if (cmd.cpl)
        begin
            res_tag_reg <= tag_in_reg;
            if (outc_reg == rlrd_pkg::OUTC_OK)
            begin
                res_ev_reg    <= rlrd_pkg::EV_DONE;
                res_att_reg   <= att_in_reg;
                res_delay_reg <= '0;
            end
            else if (retry)
            begin
                res_att_reg <= na;
                if (q_full)
                begin
                    res_ev_reg    <= rlrd_pkg::EV_LOST;
                    res_delay_reg <= '0;
                end
                else
                begin
                    res_ev_reg    <= rlrd_pkg::EV_RETRY;
                    res_delay_reg <= delay;
                    q_tag_reg[count_reg[IDX_W-1:0]]  <= tag_in_reg;
                    q_att_reg[count_reg[IDX_W-1:0]]  <= na;
                    q_elig_reg[count_reg[IDX_W-1:0]] <= now_reg + {16'd0, delay};
                end
            end
            else
            begin
                res_ev_reg    <= rlrd_pkg::EV_DROP;
                res_att_reg   <= att_in_reg;
                res_delay_reg <= '0;
            end
        end
        if (cmd.emit)
        begin
            out_ev_reg    <= res_ev_reg;
            out_tag_reg   <= res_tag_reg;
            out_att_reg   <= res_att_reg;
            out_delay_reg <= res_delay_reg;
            out_q_reg     <= count_reg;
            out_infl_reg  <= issued_reg;
        end
    end

    assign sts.cmd_code = command;
    assign sts.q_full   = q_full;
    assign sts.issue_ok = issue_ok;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign event_res       = out_ev_reg;
    assign result_tag      = out_tag_reg;
    assign result_attempts = out_att_reg;
    assign retry_delay     = out_delay_reg;
    assign queued          = out_q_reg;
    assign in_flight       = out_infl_reg;

endmodule

// File: sv/rate_limited_retry_dispatcher_top.sv
// Rate-limited retry dispatcher. Takes one word at a time on the input channel
// (tick, enqueue or completion) and gives at most one result word per input.
// A tick keeps the input stalled while it forms the milli-token refill
// products, scales them by 1/TICKS_PER_SECOND with a reciprocal multiply,
// refills the buckets, tests all queue entries for eligibility, and
// picks and issues; when a request issues, the emit state hands the
// result to the output register. None of these steps depends on QUEUE_DEPTH.
// An enqueue passes through the enqueue state, and through the emit state
// as well when it is refused; a completion passes through the completion
// state and the emit state, which registers its result for the output.
// The output register frees the datapath: a new input word is taken while a
// finished result waits, and a result is held only when the previous one is
// still stalled, which then stalls the input. Configuration writes are always
// ready and should be issued only while the block is idle.
module rate_limited_retry_dispatcher_top #(
    parameter int QUEUE_DEPTH      = 16,
    parameter int TICKS_PER_SECOND = 1000,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [15:0]       order_tag,
    input  logic [7:0]        attempts,
    input  logic [1:0]        outcome,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        event_res,
    output logic [15:0]       result_tag,
    output logic [7:0]        result_attempts,
    output logic [15:0]       retry_delay,
    output logic [CNT_W-1:0]  queued,
    output logic [7:0]        in_flight,
    // config write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    rlrd_pkg::ctrl_cmd_t cmd;
    rlrd_pkg::ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    rlrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rlrd_dp #(
        .QUEUE_DEPTH      (QUEUE_DEPTH),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (command),
        .order_tag       (order_tag),
        .attempts        (attempts),
        .outcome         (outcome),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_res       (event_res),
        .result_tag      (result_tag),
        .result_attempts (result_attempts),
        .retry_delay     (retry_delay),
        .queued          (queued),
        .in_flight       (in_flight),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

// File: sv/rlrd_checker.sv
`include "assert_macros.svh"

module rlrd_checker #(
    parameter int QUEUE_DEPTH = 16,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [1:0]       command,
    input logic             out_valid,
    input logic             out_stall,
    input logic [2:0]       event_res,
    input logic [15:0]      retry_delay,
    input logic [CNT_W-1:0] queued
);

    logic in_word;
    logic non_retry;

    assign in_word   = in_valid && !in_stall && (command != rlrd_pkg::CMD_NOP);
    assign non_retry = out_valid && (event_res != rlrd_pkg::EV_RETRY);

    `RLRD_ASSERT_NEXT(a_busy_after_word, clk, rst_n, in_word, in_stall)
    `RLRD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `RLRD_ASSERT_NOW(a_delay_only_retry, clk, rst_n, non_retry, retry_delay == 16'd0)
    `RLRD_ASSERT_NOW(a_queued_bound, clk, rst_n, out_valid, queued <= CNT_W'(QUEUE_DEPTH))

endmodule

bind rate_limited_retry_dispatcher_top rlrd_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rlrd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .retry_delay (retry_delay),
    .queued      (queued)
);
